FILE: rtl/mec_pkg.sv
package mec_pkg;

    // Fixed-point format of coordinates and iterates
    localparam int FRACTION_BITS = 27;
    localparam int COUNT_BITS    = 24;

    // Field and register widths
    localparam int COORD_W  = 32;
    localparam int STEP_W   = 31;
    localparam int INDEX_W  = 16;
    localparam int LIMIT_W  = 24;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam int IN_TDATA_W  = 2 * INDEX_W;
    localparam int OUT_TDATA_W = ((COUNT_BITS + 7) / 8) * 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REAL_LEFT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_LOWER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd4;

    // Reset values
    localparam logic [COORD_W-1:0] RST_REAL_LEFT  = 32'hF000_0000;
    localparam logic [STEP_W-1:0]  RST_REAL_STEP  = 31'd524288;
    localparam logic [COORD_W-1:0] RST_IMAG_LOWER = 32'hF000_0000;
    localparam logic [STEP_W-1:0]  RST_IMAG_STEP  = 31'd524288;
    localparam logic [LIMIT_W-1:0] RST_LIMIT      = 24'd1000;

    // Escape threshold: 4.0 in the scale of a square, 2*FRACTION_BITS fraction bits
    localparam int              THR_SHIFT     = 2 * FRACTION_BITS + 2;
    localparam bit              CAN_ESCAPE    = (THR_SHIFT < 64);
    localparam logic [64:0]     ESC_THRESHOLD = CAN_ESCAPE ? (65'd1 << THR_SHIFT) : 65'd0;

    // Point queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] real_left;
        logic        [STEP_W-1:0]  real_step;
        logic signed [COORD_W-1:0] imag_lower;
        logic        [STEP_W-1:0]  imag_step;
    } mec_cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] c_re;
        logic signed [COORD_W-1:0] c_im;
    } mec_point_t;

    // Saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh0_7FFF_FFFF;
        lo = -66'sh0_8000_0000;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

FILE: rtl/mec_front.sv
module mec_front
    import mec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mec_cfg_t              cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [INDEX_W-1:0]    column,
    input  logic [INDEX_W-1:0]    row,
    output logic                  push_valid,
    input  logic                  push_ready,
    output mec_point_t            push_point
);

    localparam int PROD_W = INDEX_W + STEP_W;

    logic                 p_valid_reg;
    logic                 p_valid_next;
    logic [PROD_W-1:0]    re_prod_reg;
    logic [PROD_W-1:0]    im_prod_reg;

    logic signed [65:0]   re_sum;
    logic signed [65:0]   im_sum;

    // Take a new pixel whenever the product stage is empty or drains this cycle
    assign in_ready   = !p_valid_reg || push_ready;
    assign push_valid = p_valid_reg;

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (in_valid && in_ready)
            p_valid_next = 1'b1;
        else if (push_ready)
            p_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= p_valid_next;
    end

    // Scale the indices by the step sizes
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            re_prod_reg <= PROD_W'(column) * PROD_W'(cfg.real_step);
            im_prod_reg <= PROD_W'(row) * PROD_W'(cfg.imag_step);
        end
    end

    // Offset by the image edges and clamp to the coordinate range
    always_comb
    begin
        re_sum = {{(66-COORD_W){cfg.real_left[COORD_W-1]}}, cfg.real_left}
               + {{(66-PROD_W){1'b0}}, re_prod_reg};
        im_sum = {{(66-COORD_W){cfg.imag_lower[COORD_W-1]}}, cfg.imag_lower}
               + {{(66-PROD_W){1'b0}}, im_prod_reg};
        push_point.c_re = sat32(re_sum);
        push_point.c_im = sat32(im_sum);
    end

endmodule

FILE: rtl/mec_queue.sv
module mec_queue
    import mec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  mec_point_t  push_point,
    output logic        pop_valid,
    input  logic        pop_ready,
    output mec_point_t  pop_point
);

    mec_point_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   fill_reg;
    logic [QCNT_W-1:0]   fill_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_point  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance the pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_point;
    end

endmodule

FILE: rtl/mec_back.sv
module mec_back
    import mec_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [LIMIT_W-1:0]      iteration_limit,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  mec_point_t              pop_point,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COUNT_BITS-1:0]   escape_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [LIMIT_W-1:0]         out_count_reg;

    logic signed [COORD_W-1:0]  x_reg;
    logic signed [COORD_W-1:0]  y_reg;
    logic signed [COORD_W-1:0]  x_next;
    logic signed [COORD_W-1:0]  y_next;
    logic signed [COORD_W-1:0]  cre_reg;
    logic signed [COORD_W-1:0]  cim_reg;
    logic [LIMIT_W-1:0]         count_reg;
    logic signed [63:0]         xx_reg;
    logic signed [63:0]         yy_reg;
    logic signed [63:0]         xy_reg;

    logic [64:0]                mag;
    logic signed [63:0]         diff;
    logic signed [63:0]         re_shift;
    logic signed [63:0]         im_shift;
    logic signed [65:0]         re_sum;
    logic signed [65:0]         im_sum;
    logic                       finished;
    logic                       out_free;
    logic                       load_out;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == ST_IDLE);

    // Escape test on the current iterate, whose squares were just formed
    always_comb
    begin
        mag      = {1'b0, xx_reg} + {1'b0, yy_reg};
        finished = (count_reg >= iteration_limit)
                || (CAN_ESCAPE && (count_reg != '0) && (mag >= ESC_THRESHOLD));
    end

    // Next iterate from the registered products
    always_comb
    begin
        diff     = xx_reg - yy_reg;
        re_shift = diff >>> FRACTION_BITS;
        im_shift = xy_reg >>> (FRACTION_BITS - 1);
        re_sum   = {{2{re_shift[63]}}, re_shift} + {{(66-COORD_W){cre_reg[COORD_W-1]}}, cre_reg};
        im_sum   = {{2{im_shift[63]}}, im_shift} + {{(66-COORD_W){cim_reg[COORD_W-1]}}, cim_reg};
        x_next   = sat32(re_sum);
        y_next   = sat32(im_sum);
    end

    // Sequencer: load a point, then alternate squaring and update
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (finished)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the transaction on the output completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    cre_reg   <= pop_point.c_re;
                    cim_reg   <= pop_point.c_im;
                    x_reg     <= '0;
                    y_reg     <= '0;
                    count_reg <= '0;
                end
            end
            ST_MUL:
            begin
                xx_reg <= 64'(x_reg) * 64'(x_reg);
                yy_reg <= 64'(y_reg) * 64'(y_reg);
                xy_reg <= 64'(x_reg) * 64'(y_reg);
            end
            ST_STEP:
            begin
                if (!finished)
                begin
                    x_reg     <= x_next;
                    y_reg     <= y_next;
                    count_reg <= count_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
            out_count_reg <= count_reg;
    end

    assign out_valid    = out_valid_reg;
    assign escape_count = COUNT_BITS'(out_count_reg);

`ifndef SYNTH
    a_mul_then_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_STEP))
        else $error("squaring not followed by update");

    a_count_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && state_next == ST_MUL) |=>
        (count_reg == $past(count_reg) + 1'b1))
        else $error("iteration count did not advance by one");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("finished pixel left no result");

    a_load_point: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && pop_valid) |=> (state_reg == ST_MUL && count_reg == '0))
        else $error("queued point not started");
`endif

endmodule

FILE: rtl/mandelbrot_escape_count.sv
// Channel   Direction  Transaction carries
// s_*       in         s_tdata[15:0] column, s_tdata[31:16] row
// m_*       out        m_tdata[23:0] escape_count
// cfg_*     in         cfg_index selects register, cfg_data is the value
//
// A pixel that runs N iterations holds the back end for a load state, a
// squaring and an update state per iteration through the shared
// 32x32 multiplier set, then a final squaring and escape test pair.
// The front end registers the scaled indices; the queue behind it holds two points.
// Reset is asynchronous and clears all handshake state; registers return to
// their defaults. A stalled output holds the result and the back end waits.
module mandelbrot_escape_count
    import mec_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_TDATA_W-1:0]    s_tdata,   // column, row
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_TDATA_W-1:0]   m_tdata,   // escape_count, zero fill
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    mec_cfg_t               cfg_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic                   push_valid;
    logic                   push_ready;
    mec_point_t             push_point;
    logic                   pop_valid;
    logic                   pop_ready;
    mec_point_t             pop_point;
    logic [COUNT_BITS-1:0]  escape_count;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_left  <= RST_REAL_LEFT;
            cfg_reg.real_step  <= RST_REAL_STEP;
            cfg_reg.imag_lower <= RST_IMAG_LOWER;
            cfg_reg.imag_step  <= RST_IMAG_STEP;
            limit_reg          <= RST_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REAL_LEFT:       cfg_reg.real_left  <= cfg_data[COORD_W-1:0];
                REG_REAL_STEP:       cfg_reg.real_step  <= cfg_data[STEP_W-1:0];
                REG_IMAG_LOWER:      cfg_reg.imag_lower <= cfg_data[COORD_W-1:0];
                REG_IMAG_STEP:       cfg_reg.imag_step  <= cfg_data[STEP_W-1:0];
                REG_ITERATION_LIMIT: limit_reg          <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .column     (s_tdata[INDEX_W-1:0]),
        .row        (s_tdata[2*INDEX_W-1:INDEX_W]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_point (push_point)
    );

    mec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_point (push_point),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_point  (pop_point)
    );

    mec_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .iteration_limit (limit_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_point       (pop_point),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .escape_count    (escape_count)
    );

    assign m_tdata = OUT_TDATA_W'(escape_count);

endmodule
